// File: sv/pwm_measure_average_macros.svh
// Assertion macros shared by the PWM measurement block.
`ifndef PWM_MEASURE_AVERAGE_MACROS_SVH
`define PWM_MEASURE_AVERAGE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PMAVG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define PMAVG_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/pmavg_pkg.sv
// Package with the types and constants of the PWM measurement block.
package pmavg_pkg;

  // Field widths.
  localparam int FREQ_W     = 26;
  localparam int DUTY_W     = 7;
  localparam int COUNT_W    = 32;
  localparam int ACTION_W   = 2;
  localparam int PROD_W     = COUNT_W + DUTY_W;

  // Bit-serial divider geometry.
  localparam int DIV_REM_W  = 32;
  localparam int DIV_NUM_W  = 26;
  localparam int DIV_STEP_W = 5;

  // Action codes carried in tuser.
  localparam logic [ACTION_W-1:0] ACT_CAPTURE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // Register map and reset value.
  localparam int              CFG_ADDR_W    = 3;
  localparam logic            REG_TICK_RATE = 1'b0;
  localparam logic [FREQ_W-1:0] TICK_RESET  = 26'd1000000;

  // Saturated duty value and step counts for the divider passes.
  localparam logic [DUTY_W-1:0]     DUTY_MAX   = 7'd100;
  localparam logic [DIV_STEP_W-1:0] STEPS_FREQ = 5'd26;
  localparam logic [DIV_STEP_W-1:0] STEPS_DUTY = 5'd7;

  // Start request for one divider pass.
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  // Commands to the averaging window.
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctl_t;

endpackage

// File: sv/pmavg_div.sv
// Restoring divider that retires one quotient bit per cycle.
module pmavg_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pmavg_pkg::div_req_t              req,
  input  logic [pmavg_pkg::DIV_REM_W-1:0]  divisor,
  input  logic [pmavg_pkg::DIV_REM_W-1:0]  rem_init,
  input  logic [pmavg_pkg::DIV_NUM_W-1:0]  num,
  output logic                             busy,
  output logic [pmavg_pkg::DIV_NUM_W-1:0]  quot
);

  logic                              busy_r;
  logic [pmavg_pkg::DIV_STEP_W-1:0]  cnt_r;
  logic [pmavg_pkg::DIV_REM_W-1:0]   rem_r;
  logic [pmavg_pkg::DIV_REM_W-1:0]   dvs_r;
  logic [pmavg_pkg::DIV_NUM_W-1:0]   num_r;
  logic [pmavg_pkg::DIV_NUM_W-1:0]   quot_r;

  logic [pmavg_pkg::DIV_REM_W:0]     shifted;
  logic [pmavg_pkg::DIV_REM_W:0]     diff;
  logic                              ge;

  // One trial subtraction with the next numerator bit brought down.
  assign shifted = {rem_r, num_r[pmavg_pkg::DIV_NUM_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == pmavg_pkg::DIV_STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder, numerator and quotient shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= rem_init;
      dvs_r  <= divisor;
      num_r  <= num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[pmavg_pkg::DIV_REM_W-1:0] : shifted[pmavg_pkg::DIV_REM_W-1:0];
      num_r  <= {num_r[pmavg_pkg::DIV_NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[pmavg_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

// File: sv/pmavg_win.sv
// Sliding sample window with running sums for frequency and duty.
`include "pwm_measure_average_macros.svh"

module pmavg_win #(
  parameter int WINDOW  = 10,
  parameter int CNT_W   = 4,
  parameter int PTR_W   = 4,
  parameter int FSUM_W  = 30,
  parameter int DSUM_W  = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmavg_pkg::win_ctl_t           ctl,
  input  logic [pmavg_pkg::FREQ_W-1:0]  sample_freq,
  input  logic [pmavg_pkg::DUTY_W-1:0]  sample_duty,
  output logic                          busy,
  output logic [FSUM_W-1:0]             fsum,
  output logic [DSUM_W-1:0]             dsum,
  output logic [CNT_W-1:0]              count
);

  localparam int ENT_W = pmavg_pkg::FREQ_W + pmavg_pkg::DUTY_W;

  logic [ENT_W-1:0]               mem [WINDOW];
  logic [ENT_W-1:0]               old_r;
  logic [pmavg_pkg::FREQ_W-1:0]   samp_f_r;
  logic [pmavg_pkg::DUTY_W-1:0]   samp_d_r;
  logic                           phase_r;
  logic [PTR_W-1:0]               wr_ptr_r;
  logic [CNT_W-1:0]               fill_r;
  logic [FSUM_W-1:0]              fsum_r;
  logic [DSUM_W-1:0]              dsum_r;
  logic                           full;
  logic [FSUM_W-1:0]              fsum_nxt;
  logic [DSUM_W-1:0]              dsum_nxt;

  assign full = (fill_r == CNT_W'(WINDOW));

  // Running sums: add the new sample, drop the oldest once the window is full.
  always_comb begin
    fsum_nxt = fsum_r + FSUM_W'(samp_f_r);
    dsum_nxt = dsum_r + DSUM_W'(samp_d_r);
    if (full) begin
      fsum_nxt = fsum_nxt - FSUM_W'(old_r[pmavg_pkg::FREQ_W-1:0]);
      dsum_nxt = dsum_nxt - DSUM_W'(old_r[ENT_W-1:pmavg_pkg::FREQ_W]);
    end
  end

  // Sample store: the oldest entry is read at the write slot before it is replaced.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      old_r    <= mem[wr_ptr_r];
      samp_f_r <= sample_freq;
      samp_d_r <= sample_duty;
    end
    if (phase_r) begin
      mem[wr_ptr_r] <= {samp_d_r, samp_f_r};
    end
  end

  // Pointer, fill count and sums.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      phase_r  <= 1'b0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      fsum_r   <= '0;
      dsum_r   <= '0;
    end else begin
      phase_r <= ctl.push;
      if (phase_r) begin
        fsum_r <= fsum_nxt;
        dsum_r <= dsum_nxt;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
        if (wr_ptr_r == PTR_W'(WINDOW - 1)) begin
          wr_ptr_r <= '0;
        end else begin
          wr_ptr_r <= wr_ptr_r + 1'b1;
        end
      end
    end
  end

  assign busy  = phase_r;
  assign fsum  = fsum_r;
  assign dsum  = dsum_r;
  assign count = fill_r;

  // The fill count never passes the window depth.
  `PMAVG_ASSERT_ALWAYS(a_fill_bound, fill_r <= CNT_W'(WINDOW), "window fill count overflow")
  // Until the window is full the write slot is the fill count.
  `PMAVG_ASSERT_IMPL(a_ptr_fill, !full, CNT_W'(wr_ptr_r) == fill_r, "write slot out of step")
  // A push is never issued while the previous one is completing.
  `PMAVG_ASSERT_IMPL(a_push_gap, phase_r, !ctl.push, "window push overlaps")

endmodule

// File: sv/pwm_measure_average.sv
// PWM input measurement: instantaneous and windowed frequency and duty cycle.
//
// Input channel: each beat carries an action in in_tuser (capture, toggle
// measuring, clear the windows) and a capture's period and high counts in
// in_tdata. A capture while measuring is on, or a toggle back on with a held
// capture, yields one output beat; other actions yield none. A capture taken
// while measuring is off is held, the latest one replacing any earlier.
// Output channel: one beat with frequency, duty and their window means.
// Configuration: APB register 0 holds the counter tick rate in hertz.
// Each result takes two 26-step passes of the bit-serial frequency divider,
// for the capture and then the window means, with the window update between.
// A capture holds off the next input beat until its output beat is issued.
// Resultless actions leave the sequencer idle. One item is worked at a time.
// A new input beat is accepted while a finished output beat waits; a
// following result then waits in the sequencer until the receiver takes it.
// Reset empties both windows, turns measuring on, drops any held capture and
// sets the tick rate to one megahertz. No clearing pass is needed.
`include "pwm_measure_average_macros.svh"

module pwm_measure_average #(
  parameter int WINDOW = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // period_count[31:0], high_count[63:32]
  input  logic [pmavg_pkg::ACTION_W-1:0]      in_tuser,   // action[1:0]
  // Output stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [71:0]                         out_tdata,  // freq_hz[25:0], duty_pct[32:26],
                                                          // avg_freq_hz[58:33],
                                                          // avg_duty_pct[65:59], zeros[71:66]
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pmavg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FSUM_W = pmavg_pkg::FREQ_W + CNT_W;
  localparam int DSUM_W = pmavg_pkg::DUTY_W + CNT_W;
  localparam int FW     = pmavg_pkg::FREQ_W;
  localparam int DW     = pmavg_pkg::DUTY_W;
  localparam int RW     = pmavg_pkg::DIV_REM_W;
  localparam int NW     = pmavg_pkg::DIV_NUM_W;
  localparam int CW     = pmavg_pkg::COUNT_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_PWAIT = 4'd5;
  localparam logic [3:0] S_DIV2  = 4'd6;
  localparam logic [3:0] S_WAIT2 = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                  state_r;
  logic [3:0]                  state_nxt;
  logic [FW-1:0]               tick_r;
  logic                        meas_r;
  logic                        pend_valid_r;
  logic [CW-1:0]               pend_period_r;
  logic [CW-1:0]               pend_high_r;
  logic [CW-1:0]               op_period_r;
  logic [CW-1:0]               op_high_r;
  logic [pmavg_pkg::PROD_W-1:0] prod_r;
  logic                        zero_r;
  logic                        sat_r;
  logic [FW-1:0]               freq_r;
  logic [DW-1:0]               duty_r;
  logic                        out_valid_r;
  logic [71:0]                 out_data_r;

  logic                        in_fire;
  logic                        cfg_wr;
  logic                        out_free;
  logic                        run_cap;
  logic                        run_pend;

  pmavg_pkg::div_req_t         req_f;
  pmavg_pkg::div_req_t         req_d;
  logic [RW-1:0]               dvs_f;
  logic [RW-1:0]               dvs_d;
  logic [RW-1:0]               rem_f;
  logic [RW-1:0]               rem_d;
  logic [NW-1:0]               num_f;
  logic [NW-1:0]               num_d;
  logic                        busy_f;
  logic                        busy_d;
  logic [NW-1:0]               quot_f;
  logic [NW-1:0]               quot_d;

  pmavg_pkg::win_ctl_t         win_ctl;
  logic                        win_busy;
  logic [FSUM_W-1:0]           fsum;
  logic [DSUM_W-1:0]           dsum;
  logic [CNT_W-1:0]            count;

  assign in_fire  = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Decode of the accepted beat.
  assign run_cap  = in_fire && (in_tuser == pmavg_pkg::ACT_CAPTURE) && meas_r;
  assign run_pend = in_fire && (in_tuser == pmavg_pkg::ACT_TOGGLE) && !meas_r && pend_valid_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= pmavg_pkg::TICK_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == pmavg_pkg::REG_TICK_RATE)) begin
      tick_r <= cfg_pwdata[FW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == pmavg_pkg::REG_TICK_RATE) ? 32'(tick_r) : '0;

  // Measuring flag and held capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r       <= 1'b1;
      pend_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (in_tuser == pmavg_pkg::ACT_TOGGLE) begin
        meas_r <= !meas_r;
        if (!meas_r) begin
          pend_valid_r <= 1'b0;
        end
      end else if (in_tuser == pmavg_pkg::ACT_CAPTURE && !meas_r) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == pmavg_pkg::ACT_CAPTURE && !meas_r) begin
      pend_period_r <= in_tdata[CW-1:0];
      pend_high_r   <= in_tdata[2*CW-1:CW];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (run_cap || run_pend) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV1;
      S_DIV1:  state_nxt = S_WAIT1;
      S_WAIT1: if (!busy_f && !busy_d) state_nxt = S_PUSH;
      S_PUSH:  state_nxt = S_PWAIT;
      S_PWAIT: if (!win_busy) state_nxt = S_DIV2;
      S_DIV2:  state_nxt = S_WAIT2;
      S_WAIT2: if (!busy_f && !busy_d) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operands of the capture being worked.
  always_ff @(posedge clk) begin
    if (run_cap) begin
      op_period_r <= in_tdata[CW-1:0];
      op_high_r   <= in_tdata[2*CW-1:CW];
    end else if (run_pend) begin
      op_period_r <= pend_period_r;
      op_high_r   <= pend_high_r;
    end
  end

  // High count times 100 as a sum of shifts; zero and saturation flags.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= {op_high_r, 7'b0} - {2'b0, op_high_r, 5'b0} + {5'b0, op_high_r, 2'b0};
      zero_r <= (op_period_r == '0);
      sat_r  <= (op_high_r >= op_period_r);
    end
  end

  // Instantaneous results once the first divider pass ends.
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT1 && !busy_f && !busy_d) begin
      freq_r <= zero_r ? '0 : quot_f;
      duty_r <= zero_r ? '0 : (sat_r ? pmavg_pkg::DUTY_MAX : quot_d[DW-1:0]);
    end
  end

  // Divider operands: capture quotients first, window means second.
  always_comb begin
    req_f.start = (state_r == S_DIV1) || (state_r == S_DIV2);
    req_f.steps = pmavg_pkg::STEPS_FREQ;
    req_d.start = req_f.start;
    req_d.steps = pmavg_pkg::STEPS_DUTY;
    if (state_r == S_DIV2) begin
      dvs_f = RW'(count);
      rem_f = RW'(fsum[FSUM_W-1:FW]);
      num_f = fsum[FW-1:0];
      dvs_d = RW'(count);
      rem_d = RW'(dsum[DSUM_W-1:DW]);
      num_d = {dsum[DW-1:0], (NW-DW)'(0)};
    end else begin
      dvs_f = op_period_r;
      rem_f = '0;
      num_f = tick_r;
      dvs_d = op_period_r;
      rem_d = prod_r[pmavg_pkg::PROD_W-1:DW];
      num_d = {prod_r[DW-1:0], (NW-DW)'(0)};
    end
  end

  pmavg_div u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_f),
    .divisor  (dvs_f),
    .rem_init (rem_f),
    .num      (num_f),
    .busy     (busy_f),
    .quot     (quot_f)
  );

  pmavg_div u_div_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_d),
    .divisor  (dvs_d),
    .rem_init (rem_d),
    .num      (num_d),
    .busy     (busy_d),
    .quot     (quot_d)
  );

  // Window commands.
  assign win_ctl.push  = (state_r == S_PUSH);
  assign win_ctl.clear = in_fire && (in_tuser == pmavg_pkg::ACT_CLEAR);

  pmavg_win #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .PTR_W  (PTR_W),
    .FSUM_W (FSUM_W),
    .DSUM_W (DSUM_W)
  ) u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (win_ctl),
    .sample_freq (freq_r),
    .sample_duty (duty_r),
    .busy        (win_busy),
    .fsum        (fsum),
    .dsum        (dsum),
    .count       (count)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {6'b0, quot_d[DW-1:0], quot_f, duty_r, freq_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A held capture exists only while measuring is off.
  `PMAVG_ASSERT_ALWAYS(a_pend_off, !(pend_valid_r && meas_r), "held capture while measuring")
  // Reported duty and mean duty never exceed 100 percent.
  `PMAVG_ASSERT_IMPL(a_duty_max, out_tvalid,
                     out_tdata[32:26] <= pmavg_pkg::DUTY_MAX, "duty above 100")
  `PMAVG_ASSERT_IMPL(a_avg_duty_max, out_tvalid,
                     out_tdata[65:59] <= pmavg_pkg::DUTY_MAX, "mean duty above 100")
  // The mean pass always divides by a nonzero fill count.
  `PMAVG_ASSERT_IMPL(a_fill_nonzero, state_r == S_DIV2, count != '0, "empty window at mean")

endmodule
